// File: sv/bwm_pkg.sv
// Shared constants, codes and types of the breakpoint and watchpoint matcher.
package bwm_pkg;

  localparam int BP_ENTRIES = 16;
  localparam int WP_ENTRIES = 16;

  localparam int SCAN_LEN = (BP_ENTRIES > WP_ENTRIES) ? BP_ENTRIES : WP_ENTRIES;
  localparam int CNT_W    = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
  localparam int BP_IW    = (BP_ENTRIES > 1) ? $clog2(BP_ENTRIES) : 1;
  localparam int WP_IW    = (WP_ENTRIES > 1) ? $clog2(WP_ENTRIES) : 1;

  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SCAN_LEN - 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } bwm_cmd_t;

  typedef enum logic [1:0] {
    PT_BREAK  = 2'd0,
    PT_WRITE  = 2'd1,
    PT_READ   = 2'd2,
    PT_ACCESS = 2'd3
  } bwm_pt_t;

  typedef enum logic [1:0] {
    AC_NONE  = 2'd0,
    AC_LOAD  = 2'd1,
    AC_STORE = 2'd2
  } bwm_ac_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } bwm_state_t;

  typedef struct packed {
    logic [63:0] addr;
    logic [15:0] kind;
  } bwm_bp_entry_t;

  typedef struct packed {
    logic [1:0]  ptype;
    logic [63:0] addr;
    logic [15:0] len;
  } bwm_wp_entry_t;

  typedef struct packed {
    logic             start;
    logic             rd_en;
    logic [CNT_W-1:0] rd_idx;
    logic             commit;
  } bwm_ctl_t;

  typedef struct packed {
    logic full;
    logic hit;
  } bwm_bp_status_t;

  typedef struct packed {
    logic full;
    logic hit_first;
    logic hit_access;
  } bwm_wp_status_t;

endpackage

// File: sv/bwm_bp_table.sv
// Breakpoint table: entry memory, valid bits, scan compare and insert or remove.
module bwm_bp_table
  import bwm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  bwm_ctl_t       ctl,
  input  logic [1:0]     cmd,
  input  logic [1:0]     ptype,
  input  logic [63:0]    paddr,
  input  logic [15:0]    plen,
  input  logic [63:0]    pc,
  output bwm_bp_status_t status
);

  bwm_bp_entry_t             bp_mem [BP_ENTRIES];
  bwm_bp_entry_t             rd_data_r;
  logic [BP_ENTRIES-1:0]     valid_r;
  logic                      cmp_vld_r;
  logic [BP_IW-1:0]          cmp_idx_r;
  logic                      held_r;
  logic                      hit_r;
  logic                      slot_found_r;
  logic [BP_IW-1:0]          slot_r;
  logic                      in_range;
  logic                      ent_valid;
  logic                      addr_eq;
  logic                      pc_eq;
  logic                      kind_eq;
  logic                      op_bp;
  logic                      do_ins;
  logic                      do_rm;

  assign in_range  = {1'b0, ctl.rd_idx} < (CNT_W + 1)'(BP_ENTRIES);
  assign op_bp     = (ptype == PT_BREAK);
  assign ent_valid = valid_r[cmp_idx_r];
  assign addr_eq   = (rd_data_r.addr == paddr);
  assign pc_eq     = (rd_data_r.addr == pc);
  assign kind_eq   = (rd_data_r.kind == plen);
  assign do_rm     = cmp_vld_r && (cmd == CMD_REMOVE) && op_bp && ent_valid && addr_eq && kind_eq;
  assign do_ins    = ctl.commit && (cmd == CMD_INSERT) && op_bp && !held_r && slot_found_r;

  assign status.full = (cmd == CMD_INSERT) && op_bp && !held_r && !slot_found_r;
  assign status.hit  = hit_r;

  always_ff @(posedge clk) begin
    if (ctl.rd_en && in_range) begin
      rd_data_r <= bp_mem[ctl.rd_idx[BP_IW-1:0]];
    end
    if (do_ins) begin
      bp_mem[slot_r] <= '{addr: paddr, kind: plen};
    end
    cmp_idx_r <= ctl.rd_idx[BP_IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      held_r       <= 1'b0;
      hit_r        <= 1'b0;
      slot_found_r <= 1'b0;
      slot_r       <= '0;
    end else begin
      cmp_vld_r <= ctl.rd_en && in_range;
      if (ctl.start) begin
        held_r       <= 1'b0;
        hit_r        <= 1'b0;
        slot_found_r <= 1'b0;
      end else if (cmp_vld_r) begin
        if (ent_valid && addr_eq) begin
          held_r <= 1'b1;
        end
        if (ent_valid && pc_eq) begin
          hit_r <= 1'b1;
        end
        if (!ent_valid && !slot_found_r) begin
          slot_found_r <= 1'b1;
          slot_r       <= cmp_idx_r;
        end
      end
      if (do_rm) begin
        valid_r[cmp_idx_r] <= 1'b0;
      end
      if (do_ins) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |-> !valid_r[slot_r])
    else $error("breakpoint insert targets an occupied entry");

  a_ins_set: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> valid_r[$past(slot_r)])
    else $error("breakpoint insert did not mark its entry valid");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !held_r && !hit_r && !slot_found_r)
    else $error("breakpoint scan flags not cleared at request start");

endmodule

// File: sv/bwm_wp_table.sv
// Watchpoint table: entry memory, valid bits, range overlap scan and insert or remove.
module bwm_wp_table
  import bwm_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  bwm_ctl_t       ctl,
  input  logic [1:0]     cmd,
  input  logic [1:0]     ptype,
  input  logic [63:0]    paddr,
  input  logic [15:0]    plen,
  input  logic [63:0]    aaddr,
  input  logic [3:0]     asize,
  input  logic [1:0]     aclass,
  output bwm_wp_status_t status
);

  bwm_wp_entry_t             wp_mem [WP_ENTRIES];
  bwm_wp_entry_t             rd_data_r;
  logic [WP_ENTRIES-1:0]     valid_r;
  logic                      cmp_vld_r;
  logic [WP_IW-1:0]          cmp_idx_r;
  logic                      hit_first_r;
  logic                      hit_acc_r;
  logic                      slot_found_r;
  logic [WP_IW-1:0]          slot_r;
  logic                      in_range;
  logic                      ent_valid;
  logic                      op_wp;
  logic                      do_ins;
  logic                      do_rm;
  logic [64:0]               d_wa;
  logic [64:0]               d_aw;
  logic                      meet;
  logic [1:0]                first_type;

  assign in_range  = {1'b0, ctl.rd_idx} < (CNT_W + 1)'(WP_ENTRIES);
  assign op_wp     = (ptype != PT_BREAK);
  assign ent_valid = valid_r[cmp_idx_r];

  // The watch and the access meet when either start lies inside the other range.
  assign d_wa = {1'b0, rd_data_r.addr} - {1'b0, aaddr};
  assign d_aw = {1'b0, aaddr} - {1'b0, rd_data_r.addr};
  assign meet = (!d_wa[64] && (d_wa[63:4] == '0) && (d_wa[3:0] < asize)) ||
                (!d_aw[64] && (d_aw[63:16] == '0) && (d_aw[15:0] < rd_data_r.len));

  assign first_type = (aclass == AC_LOAD) ? PT_READ : PT_WRITE;

  assign do_rm  = cmp_vld_r && (cmd == CMD_REMOVE) && op_wp && ent_valid &&
                  (rd_data_r.ptype == ptype) && (rd_data_r.addr == paddr) &&
                  (rd_data_r.len == plen);
  assign do_ins = ctl.commit && (cmd == CMD_INSERT) && op_wp && slot_found_r;

  assign status.full       = (cmd == CMD_INSERT) && op_wp && !slot_found_r;
  assign status.hit_first  = hit_first_r;
  assign status.hit_access = hit_acc_r;

  always_ff @(posedge clk) begin
    if (ctl.rd_en && in_range) begin
      rd_data_r <= wp_mem[ctl.rd_idx[WP_IW-1:0]];
    end
    if (do_ins) begin
      wp_mem[slot_r] <= '{ptype: ptype, addr: paddr, len: plen};
    end
    cmp_idx_r <= ctl.rd_idx[WP_IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      hit_first_r  <= 1'b0;
      hit_acc_r    <= 1'b0;
      slot_found_r <= 1'b0;
      slot_r       <= '0;
    end else begin
      cmp_vld_r <= ctl.rd_en && in_range;
      if (ctl.start) begin
        hit_first_r  <= 1'b0;
        hit_acc_r    <= 1'b0;
        slot_found_r <= 1'b0;
      end else if (cmp_vld_r) begin
        if (ent_valid && meet && (rd_data_r.ptype == first_type)) begin
          hit_first_r <= 1'b1;
        end
        if (ent_valid && meet && (rd_data_r.ptype == PT_ACCESS)) begin
          hit_acc_r <= 1'b1;
        end
        if (!ent_valid && !slot_found_r) begin
          slot_found_r <= 1'b1;
          slot_r       <= cmp_idx_r;
        end
      end
      if (do_rm) begin
        valid_r[cmp_idx_r] <= 1'b0;
      end
      if (do_ins) begin
        valid_r[slot_r] <= 1'b1;
      end
    end
  end

  a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |-> !valid_r[slot_r])
    else $error("watchpoint insert targets an occupied entry");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> !hit_first_r && !hit_acc_r && !slot_found_r)
    else $error("watchpoint scan flags not cleared at request start");

  a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> $past(ctl.rd_en))
    else $error("watchpoint compare without a preceding read");

endmodule

// File: sv/breakpoint_watchpoint_matcher.sv
// Top level of the breakpoint and watchpoint matcher: sequencer, tables and result register.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   command, point and access fields
//   out_     output     out_valid / out_ready table_full, hit, hit_cause
//
// Each request is accepted, then both table memories are read once per entry, then the last
// compare completes and the result is committed.
// Each table memory has a single read port, so its entries are read one at a time.
// Reset clears all valid bits, so both tables start empty; entry memories are not cleared.
// A new request is taken while the previous result still waits in the output register;
// the commit stalls only when the output register is still full.
module breakpoint_watchpoint_matcher
  import bwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [1:0]  in_point_type,
  input  logic [63:0] in_point_address,
  input  logic [15:0] in_point_length,
  input  logic [63:0] in_pc,
  input  logic [63:0] in_access_address,
  input  logic [3:0]  in_access_size,
  input  logic [1:0]  in_access_class,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_table_full,
  output logic        out_hit,
  output logic [1:0]  out_hit_cause
);

  bwm_state_t       state_r;
  bwm_state_t       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  bwm_ctl_t         ctl;
  bwm_bp_status_t   bp_status;
  bwm_wp_status_t   wp_status;
  logic             out_free;

  logic [1:0]       cmd_r;
  logic [1:0]       ptype_r;
  logic [63:0]      paddr_r;
  logic [15:0]      plen_r;
  logic [63:0]      pc_r;
  logic [63:0]      aaddr_r;
  logic [3:0]       asize_r;
  logic [1:0]       aclass_r;

  logic             out_valid_r;
  logic             out_full_r;
  logic             out_hit_r;
  logic [1:0]       out_cause_r;
  logic             res_full;
  logic             res_hit;
  logic [1:0]       res_cause;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == SCAN_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    ctl.start  = (state_r == ST_IDLE) && in_valid;
    ctl.rd_en  = (state_r == ST_SCAN);
    ctl.rd_idx = cnt_r;
    ctl.commit = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.start) begin
        cnt_r <= '0;
      end else if (ctl.rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r    <= in_command;
      ptype_r  <= in_point_type;
      paddr_r  <= in_point_address;
      plen_r   <= in_point_length;
      pc_r     <= in_pc;
      aaddr_r  <= in_access_address;
      asize_r  <= in_access_size;
      aclass_r <= in_access_class;
    end
  end

  bwm_bp_table u_bp_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cmd    (cmd_r),
    .ptype  (ptype_r),
    .paddr  (paddr_r),
    .plen   (plen_r),
    .pc     (pc_r),
    .status (bp_status)
  );

  bwm_wp_table u_wp_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .cmd    (cmd_r),
    .ptype  (ptype_r),
    .paddr  (paddr_r),
    .plen   (plen_r),
    .aaddr  (aaddr_r),
    .asize  (asize_r),
    .aclass (aclass_r),
    .status (wp_status)
  );

  // A breakpoint at the pc wins over any watch; a typed watch wins over an access watch.
  always_comb begin
    res_full  = bp_status.full || wp_status.full;
    res_hit   = 1'b0;
    res_cause = PT_BREAK;
    if (cmd_r == CMD_CHECK) begin
      priority if (bp_status.hit) begin
        res_hit   = 1'b1;
        res_cause = PT_BREAK;
      end else if ((aclass_r == AC_LOAD) || (aclass_r == AC_STORE)) begin
        if (wp_status.hit_first) begin
          res_hit   = 1'b1;
          res_cause = (aclass_r == AC_LOAD) ? PT_READ : PT_WRITE;
        end else if (wp_status.hit_access) begin
          res_hit   = 1'b1;
          res_cause = PT_ACCESS;
        end
      end else begin
        res_hit   = 1'b0;
        res_cause = PT_BREAK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_full_r  <= res_full;
      out_hit_r   <= res_hit;
      out_cause_r <= res_cause;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_table_full = out_full_r;
  assign out_hit        = out_hit_r;
  assign out_hit_cause  = out_cause_r;

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && (cnt_r == SCAN_LAST) |=> (state_r == ST_DRAIN))
    else $error("scan did not stop after the last entry");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("accepted request did not start a scan at entry zero");

  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> !out_hit_r)
    else $error("result reports both a full table and a hit");

endmodule

// File: bench/breakpoint_watchpoint_matcher_tb.sv
// Self-checking testbench for the breakpoint and watchpoint matcher with an in-bench model.
module breakpoint_watchpoint_matcher_tb
  import bwm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] AC_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 600;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  point_type;
    logic [63:0] point_address;
    logic [15:0] point_length;
    logic [63:0] pc;
    logic [63:0] access_address;
    logic [3:0]  access_size;
    logic [1:0]  access_class;
  } dbg_request_t;

  typedef struct packed {
    logic       table_full;
    logic       hit;
    logic [1:0] hit_cause;
  } dbg_verdict_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [1:0]  in_point_type;
  logic [63:0] in_point_address;
  logic [15:0] in_point_length;
  logic [63:0] in_pc;
  logic [63:0] in_access_address;
  logic [3:0]  in_access_size;
  logic [1:0]  in_access_class;
  logic        out_valid;
  logic        out_ready;
  logic        out_table_full;
  logic        out_hit;
  logic [1:0]  out_hit_cause;

  logic        brk_used [BP_ENTRIES];
  logic [63:0] brk_addr [BP_ENTRIES];
  logic [15:0] brk_kind [BP_ENTRIES];
  logic        wch_used [WP_ENTRIES];
  logic [1:0]  wch_type [WP_ENTRIES];
  logic [63:0] wch_addr [WP_ENTRIES];
  logic [15:0] wch_len  [WP_ENTRIES];

  dbg_verdict_t awaited_verdicts[$];
  int mismatches = 0;
  int rx_hold_cycles = 0;
  bit tx_no_gaps = 0;
  bit rx_no_gaps = 0;

  breakpoint_watchpoint_matcher dut (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic ranges_overlap(logic [63:0] a, logic [3:0] size, logic [63:0] w,
                                          logic [15:0] len);
    return ((a <= w) && ((w - a) < 64'(size))) || ((w <= a) && ((a - w) < 64'(len)));
  endfunction

  function automatic logic watch_matches(logic [1:0] kind, logic [63:0] a, logic [3:0] size);
    for (int i = 0; i < WP_ENTRIES; i++) begin
      if (wch_used[i] && wch_type[i] == kind && ranges_overlap(a, size, wch_addr[i], wch_len[i]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dbg_verdict_t debug_unit_response(dbg_request_t r);
    dbg_verdict_t v;
    int slot;
    logic held;
    logic [1:0] first;
    v = '0;
    slot = -1;
    held = 1'b0;
    case (r.command)
      CMD_INSERT: begin
        if (r.point_type == PT_BREAK) begin
          for (int i = 0; i < BP_ENTRIES; i++) begin
            if (brk_used[i] && brk_addr[i] == r.point_address) held = 1'b1;
            if (!brk_used[i] && slot < 0) slot = i;
          end
          if (!held) begin
            if (slot < 0) begin
              v.table_full = 1'b1;
            end else begin
              brk_used[slot] = 1'b1;
              brk_addr[slot] = r.point_address;
              brk_kind[slot] = r.point_length;
            end
          end
        end else begin
          for (int i = 0; i < WP_ENTRIES; i++)
            if (!wch_used[i] && slot < 0) slot = i;
          if (slot < 0) begin
            v.table_full = 1'b1;
          end else begin
            wch_used[slot] = 1'b1;
            wch_type[slot] = r.point_type;
            wch_addr[slot] = r.point_address;
            wch_len[slot] = r.point_length;
          end
        end
      end
      CMD_REMOVE: begin
        if (r.point_type == PT_BREAK) begin
          for (int i = 0; i < BP_ENTRIES; i++)
            if (brk_used[i] && brk_addr[i] == r.point_address && brk_kind[i] == r.point_length)
              brk_used[i] = 1'b0;
        end else begin
          for (int i = 0; i < WP_ENTRIES; i++)
            if (wch_used[i] && wch_type[i] == r.point_type &&
                wch_addr[i] == r.point_address && wch_len[i] == r.point_length)
              wch_used[i] = 1'b0;
        end
      end
      CMD_CHECK: begin
        for (int i = 0; i < BP_ENTRIES; i++)
          if (brk_used[i] && brk_addr[i] == r.pc) held = 1'b1;
        if (held) begin
          v.hit = 1'b1;
          v.hit_cause = PT_BREAK;
        end else if (r.access_class == AC_LOAD || r.access_class == AC_STORE) begin
          first = (r.access_class == AC_LOAD) ? PT_READ : PT_WRITE;
          if (watch_matches(first, r.access_address, r.access_size)) begin
            v.hit = 1'b1;
            v.hit_cause = first;
          end else if (watch_matches(PT_ACCESS, r.access_address, r.access_size)) begin
            v.hit = 1'b1;
            v.hit_cause = PT_ACCESS;
          end
        end
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  function automatic dbg_request_t point_req(logic [1:0] cmd, logic [1:0] ptype,
                                             logic [63:0] addr, logic [15:0] len);
    dbg_request_t r;
    r.command = cmd;
    r.point_type = ptype;
    r.point_address = addr;
    r.point_length = len;
    r.pc = rand64();
    r.access_address = rand64();
    r.access_size = 4'($urandom_range(0, 15));
    r.access_class = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic dbg_request_t check_req(logic [63:0] pc, logic [63:0] addr,
                                             logic [3:0] size, logic [1:0] aclass);
    dbg_request_t r;
    r.command = CMD_CHECK;
    r.point_type = 2'($urandom_range(0, 3));
    r.point_address = rand64();
    r.point_length = 16'($urandom);
    r.pc = pc;
    r.access_address = addr;
    r.access_size = size;
    r.access_class = aclass;
    return r;
  endfunction

  function automatic logic [63:0] pick_address();
    case ($urandom_range(0, 7))
      0, 1: return rand64();
      2: return 64'($urandom_range(0, 63));
      3: return ~64'($urandom_range(0, 63));
      default: return 64'h0000_7FFF_0000_1000 + 64'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic int live_breakpoint();
    int start;
    start = $urandom_range(0, BP_ENTRIES - 1);
    for (int k = 0; k < BP_ENTRIES; k++)
      if (brk_used[(start + k) % BP_ENTRIES]) return (start + k) % BP_ENTRIES;
    return -1;
  endfunction

  function automatic int live_watch();
    int start;
    start = $urandom_range(0, WP_ENTRIES - 1);
    for (int k = 0; k < WP_ENTRIES; k++)
      if (wch_used[(start + k) % WP_ENTRIES]) return (start + k) % WP_ENTRIES;
    return -1;
  endfunction

  // Removes and checks often aim at entries already held so that hits and exact removes occur.
  function automatic dbg_request_t random_request();
    dbg_request_t r;
    int sel;
    int j;
    logic [3:0] size;
    logic [1:0] aclass;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      r = point_req(CMD_UNUSED, 2'($urandom_range(0, 3)), rand64(), 16'($urandom));
    end else if (sel < 25) begin
      r = point_req(CMD_INSERT, 2'($urandom_range(0, 3)), pick_address(), pick_length());
    end else if (sel < 45) begin
      r = point_req(CMD_REMOVE, 2'($urandom_range(0, 3)), pick_address(), pick_length());
      if ($urandom_range(0, 9) < 7) begin
        if (r.point_type == PT_BREAK) begin
          j = live_breakpoint();
          if (j >= 0) begin
            r.point_address = brk_addr[j];
            r.point_length = brk_kind[j];
          end
        end else begin
          j = live_watch();
          if (j >= 0) begin
            r.point_type = wch_type[j];
            r.point_address = wch_addr[j];
            r.point_length = wch_len[j];
          end
        end
      end
    end else begin
      size = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      if ($urandom_range(0, 9) < 8)
        aclass = $urandom_range(0, 1) ? AC_LOAD : AC_STORE;
      else
        aclass = 2'($urandom_range(0, 3));
      r = check_req(pick_address(), pick_address(), size, aclass);
      if ($urandom_range(0, 9) < 4) begin
        j = live_breakpoint();
        if (j >= 0) r.pc = brk_addr[j];
      end
      if ($urandom_range(0, 9) < 6) begin
        j = live_watch();
        if (j >= 0)
          r.access_address = wch_addr[j] + 64'($urandom_range(0, 40)) - 64'd20;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
  endtask

  task automatic send_request(input dbg_request_t r);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= r.command;
    in_point_type <= r.point_type;
    in_point_address <= r.point_address;
    in_point_length <= r.point_length;
    in_pc <= r.pc;
    in_access_address <= r.access_address;
    in_access_size <= r.access_size;
    in_access_class <= r.access_class;
    do @(posedge clk); while (!in_ready);
    awaited_verdicts.insert(awaited_verdicts.size(), debug_unit_response(r));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_points();
    send_request(check_req(64'h0, 64'h0, 4'd8, AC_LOAD));
    send_request(point_req(CMD_INSERT, PT_BREAK, 64'h0, 16'h0000));
    send_request(point_req(CMD_INSERT, PT_BREAK, 64'h0, 16'hFFFF));
    send_request(point_req(CMD_INSERT, PT_BREAK, '1, 16'hFFFF));
    send_request(check_req('1, 64'h0, 4'd8, AC_STORE));
    send_request(point_req(CMD_INSERT, PT_WRITE, 64'h1000, 16'd4));
    send_request(point_req(CMD_INSERT, PT_READ, 64'h1000, 16'd4));
    send_request(point_req(CMD_INSERT, PT_ACCESS, 64'h1000, 16'd4));
    send_request(point_req(CMD_INSERT, PT_ACCESS, 64'h1000, 16'd4));
    send_request(check_req(64'h40, 64'h0FFC, 4'd4, AC_LOAD));
    send_request(check_req(64'h40, 64'h0FFD, 4'd4, AC_LOAD));
    send_request(check_req(64'h40, 64'h1003, 4'd1, AC_STORE));
    send_request(check_req(64'h40, 64'h1004, 4'd8, AC_STORE));
    send_request(check_req(64'h0, 64'h1000, 4'd4, AC_STORE));
    send_request(check_req(64'h40, 64'h1000, 4'd4, AC_NONE));
    send_request(check_req(64'h40, 64'h1000, 4'd4, AC_RESERVED));
    send_request(point_req(CMD_REMOVE, PT_BREAK, 64'h0, 16'hFFFF));
    send_request(point_req(CMD_REMOVE, PT_READ, 64'h1000, 16'd4));
    send_request(point_req(CMD_REMOVE, PT_WRITE, 64'h1000, 16'd5));
    send_request(check_req(64'h40, 64'h1001, 4'd15, AC_LOAD));
    send_request(point_req(CMD_REMOVE, PT_ACCESS, 64'h1000, 16'd4));
    send_request(check_req(64'h40, 64'h1000, 4'd0, AC_LOAD));
    send_request(point_req(CMD_INSERT, PT_ACCESS, 64'hFFFF_FFFF_FFFF_FFFC, 16'hFFFF));
    send_request(check_req(64'h40, 64'h0, 4'd15, AC_STORE));
    send_request(check_req(64'h40, '1, 4'd0, AC_LOAD));
    send_request(point_req(CMD_INSERT, PT_READ, 64'h2000, 16'd0));
    send_request(check_req(64'h40, 64'h2000, 4'd1, AC_LOAD));
    send_request(point_req(CMD_UNUSED, PT_BREAK, 64'h40, 16'h0000));
  endtask

  task automatic test_table_full();
    for (int i = 0; i <= BP_ENTRIES; i++)
      send_request(point_req(CMD_INSERT, PT_BREAK, 64'hC000_0000 + 64'(i * 16), 16'(i)));
    send_request(point_req(CMD_INSERT, PT_BREAK, 64'hC000_0000, 16'h0001));
    for (int i = 0; i <= WP_ENTRIES; i++)
      send_request(point_req(CMD_INSERT, 2'(PT_WRITE + i % 3), 64'hD000_0000 + 64'(i * 4),
                             16'd8));
    send_request(check_req(64'h44, 64'hD000_0004, 4'd8, AC_STORE));
    for (int i = 0; i < BP_ENTRIES; i++)
      if (brk_used[i]) send_request(point_req(CMD_REMOVE, PT_BREAK, brk_addr[i], brk_kind[i]));
    for (int i = 0; i < WP_ENTRIES; i++)
      if (wch_used[i])
        send_request(point_req(CMD_REMOVE, wch_type[i], wch_addr[i], wch_len[i]));
  endtask

  task automatic test_backpressure();
    wait_for_results();
    rx_hold_cycles = HOLD_OFF_CYCLES;
    tx_no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) send_request(random_request());
    tx_no_gaps = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 50 == 0) begin
        tx_no_gaps = ($urandom_range(0, 3) == 0);
        rx_no_gaps = ($urandom_range(0, 3) == 0);
      end
      send_request(random_request());
    end
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_no_gaps ? 0 : $urandom_range(0, 11);
      if (rx_hold_cycles > 0 || gap > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles + gap) @(posedge clk);
        rx_hold_cycles = 0;
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    dbg_verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 64'({out_table_full, out_hit, out_hit_cause}),
                        64'd0);
      end else begin
        want = awaited_verdicts.pop_front();
        if (out_table_full !== want.table_full)
          report_mismatch("table_full", 64'(out_table_full), 64'(want.table_full));
        if (out_hit !== want.hit)
          report_mismatch("hit", 64'(out_hit), 64'(want.hit));
        if (out_hit_cause !== want.hit_cause)
          report_mismatch("hit_cause", 64'(out_hit_cause), 64'(want.hit_cause));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_INSERT;
    in_point_type <= PT_BREAK;
    in_point_address <= '0;
    in_point_length <= '0;
    in_pc <= '0;
    in_access_address <= '0;
    in_access_size <= '0;
    in_access_class <= AC_NONE;
    for (int i = 0; i < BP_ENTRIES; i++) begin
      brk_used[i] = 1'b0;
      brk_addr[i] = '0;
      brk_kind[i] = '0;
    end
    for (int i = 0; i < WP_ENTRIES; i++) begin
      wch_used[i] = 1'b0;
      wch_type[i] = '0;
      wch_addr[i] = '0;
      wch_len[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_points();
    test_table_full();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
